// ===== src/tpma_pkg.sv =====
// Shared constants, widths and the CORDIC angle table for the tilt pitch unit.
// No dependencies; every other file refers to it by scoped names.
package tpma_pkg;

  // Ring depth of the moving average
  localparam int WINDOW = 10;

  // Pitch limit, +-90 degrees in 1/256 degree units
  localparam int PITCH_MAX = 23040;

  // Stream payload widths
  localparam int AXIS_W = 16;
  localparam int PITCH_W = 16;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 32;

  // Square root: 32-bit radicand, 32-bit root, 34-bit partial remainder
  localparam int RAD_W = 32;
  localparam int ROOT_W = 32;
  localparam int REM_W = ROOT_W + 2;
  localparam int ROOT_STEPS = 32;
  localparam int ROOT_CNT_W = 5;

  // CORDIC vectoring datapath
  localparam int VEC_W = 36;
  localparam int ANG_W = 25;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CNT_W = 4;

  // Ring and running sum
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = $clog2(WINDOW * PITCH_MAX + WINDOW) + 1;

  // Division of the sum by WINDOW through a reciprocal and one correction
  localparam int RECIP_K = 24;
  localparam int RECIP_W = RECIP_K + 1;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_K) / WINDOW);
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int FIX_W = SUM_W + 7;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic signed [ANG_W-1:0] atan_step(input logic [CORDIC_CNT_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    unique case (idx)
      4'd0:    val = 25'sd2949120;
      4'd1:    val = 25'sd1740967;
      4'd2:    val = 25'sd919879;
      4'd3:    val = 25'sd466945;
      4'd4:    val = 25'sd234379;
      4'd5:    val = 25'sd117304;
      4'd6:    val = 25'sd58666;
      4'd7:    val = 25'sd29335;
      4'd8:    val = 25'sd14668;
      4'd9:    val = 25'sd7334;
      4'd10:   val = 25'sd3667;
      4'd11:   val = 25'sd1833;
      4'd12:   val = 25'sd917;
      4'd13:   val = 25'sd458;
      4'd14:   val = 25'sd229;
      4'd15:   val = 25'sd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/tpma_sqrt.sv =====
// Iterative integer square root of (radicand << 32), one root bit per cycle.
// Depends on tpma_pkg for widths and step count.
module tpma_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tpma_pkg::RAD_W-1:0]    rad,
  output logic                          done,
  output logic [tpma_pkg::ROOT_W-1:0]   root
);

  logic [tpma_pkg::RAD_W-1:0]      rad_sh;
  logic [tpma_pkg::REM_W-1:0]      rem;
  logic [tpma_pkg::ROOT_CNT_W-1:0] cnt;
  logic                            busy;

  logic [tpma_pkg::REM_W+1:0] rem_sh;
  logic [tpma_pkg::REM_W+1:0] trial;
  logic                       fit;
  logic [tpma_pkg::REM_W-1:0] rem_next;

  // Bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh   = {rem, rad_sh[tpma_pkg::RAD_W-1 -: 2]};
    trial    = {2'b00, root, 2'b01};
    fit      = (rem_sh >= trial);
    rem_next = fit ? tpma_pkg::REM_W'(rem_sh - trial) : tpma_pkg::REM_W'(rem_sh);
  end

  // Step the digit recurrence; zeros shift in for the low half of the radicand
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tpma_pkg::ROOT_CNT_W'(tpma_pkg::ROOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[tpma_pkg::RAD_W-3:0], 2'b00};
      rem    <= rem_next;
      root   <= {root[tpma_pkg::ROOT_W-2:0], fit};
    end
  end

endmodule

// ===== src/tpma_cordic.sv =====
// Iterative CORDIC vectoring for the pitch angle, one micro-rotation per cycle,
// followed by rounding to 1/256 degree and saturation. Depends on tpma_pkg.
module tpma_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [tpma_pkg::ROOT_W-1:0]         mag,
  input  logic signed [tpma_pkg::AXIS_W-1:0]  accel_y,
  output logic                                done,
  output logic signed [tpma_pkg::PITCH_W-1:0] pitch
);

  logic signed [tpma_pkg::VEC_W-1:0] x;
  logic signed [tpma_pkg::VEC_W-1:0] y;
  logic signed [tpma_pkg::ANG_W-1:0] z;
  logic [tpma_pkg::CORDIC_CNT_W-1:0] idx;
  logic                              busy;

  logic signed [tpma_pkg::VEC_W-1:0] dx;
  logic signed [tpma_pkg::VEC_W-1:0] dy;
  logic signed [tpma_pkg::ANG_W-1:0] dz;

  // Shifted terms of this micro-rotation
  always_comb begin
    dx = y >>> idx;
    dy = x >>> idx;
    dz = tpma_pkg::atan_step(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == tpma_pkg::CORDIC_CNT_W'(tpma_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Rotate toward y == 0; hold when y is already zero
  always_ff @(posedge clk) begin
    if (start) begin
      x <= {{(tpma_pkg::VEC_W - tpma_pkg::ROOT_W){1'b0}}, mag};
      y <= {{(tpma_pkg::VEC_W - tpma_pkg::AXIS_W - 16){accel_y[tpma_pkg::AXIS_W-1]}},
            accel_y, 16'b0};
      z <= '0;
    end else if (busy) begin
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + dz;
      end else if (y < 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - dz;
      end
    end
  end

  // Round to 1/256 degree, ties away from zero, then clamp to +-90 degrees
  logic                         z_neg;
  logic [tpma_pkg::ANG_W-1:0]   z_abs;
  logic [tpma_pkg::ANG_W-1:0]   z_rnd;
  logic [tpma_pkg::ANG_W-9:0]   q_mag;
  logic [tpma_pkg::PITCH_W-1:0] q_sat;

  always_comb begin
    z_neg = z[tpma_pkg::ANG_W-1];
    z_abs = z_neg ? tpma_pkg::ANG_W'(-z) : tpma_pkg::ANG_W'(z);
    z_rnd = z_abs + tpma_pkg::ANG_W'(128);
    q_mag = z_rnd[tpma_pkg::ANG_W-1:8];
    if (q_mag > (tpma_pkg::ANG_W-8)'(tpma_pkg::PITCH_MAX)) begin
      q_sat = tpma_pkg::PITCH_W'(tpma_pkg::PITCH_MAX);
    end else begin
      q_sat = q_mag[tpma_pkg::PITCH_W-1:0];
    end
    pitch = z_neg ? signed'(-q_sat) : signed'(q_sat);
  end

endmodule

// ===== src/tpma_ring.sv =====
// Pitch ring memory with running sum and rounded window mean.
// Read-modify-write of one ring entry per item; depends on tpma_pkg.
module tpma_ring (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tpma_pkg::PITCH_W-1:0] pitch,
  output logic                                done,
  output logic signed [tpma_pkg::PITCH_W-1:0] mean
);

  typedef enum logic [4:0] {
    R_IDLE = 5'b00001,
    R_UPD  = 5'b00010,
    R_MUL  = 5'b00100,
    R_DIV  = 5'b01000,
    R_FIX  = 5'b10000
  } ring_state_t;

  ring_state_t state;

  // Ring storage; entries read as zero until first written
  logic signed [tpma_pkg::PITCH_W-1:0] ring_mem [tpma_pkg::WINDOW];
  logic [tpma_pkg::WINDOW-1:0]         valid;
  logic signed [tpma_pkg::PITCH_W-1:0] rd_data;
  logic [tpma_pkg::SLOT_W-1:0]         slot;
  logic signed [tpma_pkg::SUM_W-1:0]   sum;
  logic signed [tpma_pkg::PITCH_W-1:0] pitch_hold;

  logic                            neg;
  logic [tpma_pkg::SUM_W-1:0]      num;
  logic [tpma_pkg::SUM_W-1:0]      quo;

  logic signed [tpma_pkg::SUM_W-1:0] old_val;
  logic signed [tpma_pkg::SUM_W-1:0] sum_next;
  logic [tpma_pkg::SUM_W-1:0]        sum_abs;
  logic [tpma_pkg::PROD_W-1:0]       prod;
  logic [tpma_pkg::FIX_W-1:0]        rem;
  logic [tpma_pkg::SUM_W-1:0]        quo_fix;

  always_comb begin
    old_val  = valid[slot] ? tpma_pkg::SUM_W'(rd_data) : '0;
    sum_next = sum - old_val + tpma_pkg::SUM_W'(pitch_hold);
    sum_abs  = sum[tpma_pkg::SUM_W-1] ? tpma_pkg::SUM_W'(-sum) : tpma_pkg::SUM_W'(sum);
    prod     = tpma_pkg::PROD_W'(num) * tpma_pkg::PROD_W'(tpma_pkg::RECIP_M);
    rem      = tpma_pkg::FIX_W'(num)
             - tpma_pkg::FIX_W'(quo) * tpma_pkg::FIX_W'(tpma_pkg::WINDOW);
    quo_fix  = (rem >= tpma_pkg::FIX_W'(tpma_pkg::WINDOW)) ? quo + 1'b1 : quo;
  end

  // Read the entry about to be replaced; write back the new pitch
  always_ff @(posedge clk) begin
    if (start) begin
      rd_data    <= ring_mem[slot];
      pitch_hold <= pitch;
    end
    if (state == R_UPD) begin
      ring_mem[slot] <= pitch_hold;
    end
  end

  // Sequence: update sum, multiply by reciprocal, correct and emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      valid <= '0;
      slot  <= '0;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (start) begin
            state <= R_UPD;
          end
        end
        R_UPD: begin
          sum         <= sum_next;
          valid[slot] <= 1'b1;
          slot <= (slot == tpma_pkg::SLOT_W'(tpma_pkg::WINDOW - 1)) ? '0 : slot + 1'b1;
          state       <= R_MUL;
        end
        R_MUL: begin
          state <= R_DIV;
        end
        R_DIV: begin
          state <= R_FIX;
        end
        R_FIX: begin
          done  <= 1'b1;
          state <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  // Divider datapath registers
  always_ff @(posedge clk) begin
    if (state == R_MUL) begin
      neg <= sum[tpma_pkg::SUM_W-1];
      num <= sum_abs + tpma_pkg::SUM_W'(tpma_pkg::WINDOW / 2);
    end
    if (state == R_FIX) begin
      mean <= neg ? signed'(-quo_fix[tpma_pkg::PITCH_W-1:0])
                  : signed'(quo_fix[tpma_pkg::PITCH_W-1:0]);
    end
  end

  // Reciprocal product uses num registered in the preceding R_MUL state
  logic mul_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
    end else begin
      mul_pend <= (state == R_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_pend) begin
      quo <= prod[tpma_pkg::RECIP_K +: tpma_pkg::SUM_W];
    end
  end

endmodule

// ===== src/tilt_pitch_moving_average_unit.sv =====
// Top level of the tilt pitch unit: stream ports, squaring, sequencing.
// Depends on tpma_pkg, tpma_sqrt, tpma_cordic and tpma_ring.
//
// One accelerometer beat in gives one result beat out: the pitch
// atan2(y, sqrt(x^2 + z^2)) in 1/256 degree and the rounded mean of the
// last WINDOW pitches (ring cleared by reset, so early means include zeros).
// Items are processed one at a time. An item goes from its accepting edge
// through squaring and sum, the square-root unit (one root bit per step),
// the CORDIC unit (one rotation per step), the ring read-modify-write and
// reciprocal divide, and hand-offs between the stages, to the edge that
// loads its result beat into the output register; the next input beat can
// be taken in the cycle after that load. A result beat that is not yet
// taken holds the next result in the emit state and stalls the input for
// as long. The ring is cleared at reset through per-entry valid bits, with
// no clearing pass.
module tilt_pitch_moving_average_unit (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [tpma_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // m_tdata: pitch_now [15:0], pitch_mean [31:16]
  output logic [tpma_pkg::M_DATA_W-1:0]     m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQUARE = 7'b0000010,
    S_SUMSQ  = 7'b0000100,
    S_ROOT   = 7'b0001000,
    S_ANGLE  = 7'b0010000,
    S_AVG    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } top_state_t;

  top_state_t state;

  logic signed [tpma_pkg::AXIS_W-1:0] accel_x;
  logic signed [tpma_pkg::AXIS_W-1:0] accel_y;
  logic signed [tpma_pkg::AXIS_W-1:0] accel_z;
  logic signed [2*tpma_pkg::AXIS_W-1:0] sq_x;
  logic signed [2*tpma_pkg::AXIS_W-1:0] sq_z;

  logic [tpma_pkg::RAD_W-1:0]          rad;
  logic                                root_done;
  logic [tpma_pkg::ROOT_W-1:0]         root;
  logic                                angle_done;
  logic signed [tpma_pkg::PITCH_W-1:0] pitch_now;
  logic                                avg_done;
  logic signed [tpma_pkg::PITCH_W-1:0] pitch_mean;

  logic in_beat;
  logic out_free;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rad      = tpma_pkg::RAD_W'($unsigned(sq_x)) + tpma_pkg::RAD_W'($unsigned(sq_z));

  // Capture the sample and square the horizontal axes
  always_ff @(posedge clk) begin
    if (in_beat) begin
      accel_x <= s_tdata[15:0];
      accel_y <= s_tdata[31:16];
      accel_z <= s_tdata[47:32];
    end
    if (state == S_SQUARE) begin
      sq_x <= accel_x * accel_x;
      sq_z <= accel_z * accel_z;
    end
  end

  tpma_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SUMSQ),
    .rad   (rad),
    .done  (root_done),
    .root  (root)
  );

  tpma_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   ((state == S_ROOT) && root_done),
    .mag     (root),
    .accel_y (accel_y),
    .done    (angle_done),
    .pitch   (pitch_now)
  );

  tpma_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_ANGLE) && angle_done),
    .pitch (pitch_now),
    .done  (avg_done),
    .mean  (pitch_mean)
  );

  // Advance the item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          state <= S_SUMSQ;
        end
        S_SUMSQ: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          if (angle_done) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          if (avg_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load the result beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      m_tdata <= {pitch_mean, pitch_now};
    end
  end

endmodule

// ===== src/tpma_checker.sv =====
// Port-level checks for the tilt pitch unit, bound to the top level.
// Depends on tpma_pkg for the pitch limit.
module tpma_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tpma_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready
);

  localparam logic signed [15:0] LIM_HI = 16'(tpma_pkg::PITCH_MAX);
  localparam logic signed [15:0] LIM_LO = 16'(-tpma_pkg::PITCH_MAX);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // One item at a time: no input beat right after one is taken
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  // Instant pitch stays within +-90 degrees
  a_now_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= LIM_HI) && ($signed(m_tdata[15:0]) >= LIM_LO))
    else $error("pitch_now out of range");

  // Mean stays within +-90 degrees
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= LIM_HI) && ($signed(m_tdata[31:16]) >= LIM_LO))
    else $error("pitch_mean out of range");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid after reset");

endmodule

bind tilt_pitch_moving_average_unit tpma_checker u_tpma_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== dv/tb_tilt_pitch_moving_average_unit.sv =====
// Testbench for tilt_pitch_moving_average_unit: drives accelerometer beats and checks
// each pitch / window-mean result against an in-bench pitch and ring tracker.
// Depends on tpma_pkg and the unit under test.
module tb_tilt_pitch_moving_average_unit;

  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CALM_ITEMS   = 150;
  localparam int SQUEEZE_LEN  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_MAX   = 10;

  // atan(2^-i) in 1/65536 degree
  localparam longint ATAN_DEG16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    logic signed [tpma_pkg::PITCH_W-1:0] pitch_now;
    logic signed [tpma_pkg::PITCH_W-1:0] pitch_mean;
  } pitch_result_t;

  // Tracks the pitch ring and running sum, queues the results due from the unit
  class pitch_tracker;
    logic signed [tpma_pkg::PITCH_W-1:0] ring [tpma_pkg::WINDOW];
    int            ring_total;
    int            next_slot;
    int            mismatch_cnt;
    pitch_result_t pitch_due_q [$];

    function new();
      foreach (ring[i]) ring[i] = '0;
      ring_total   = 0;
      next_slot    = 0;
      mismatch_cnt = 0;
    endfunction

    // Exact integer square root, bit by bit
    function longint unsigned root64(longint unsigned n);
      longint unsigned res;
      longint unsigned probe;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= res + probe) begin
          n   = n - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res = res >> 1;
        end
        probe = probe >> 2;
      end
      return res;
    endfunction

    // Pitch in 1/256 degree: CORDIC vectoring on (sqrt(x^2+z^2), y)
    function logic signed [tpma_pkg::PITCH_W-1:0] tilt_angle(
        logic signed [tpma_pkg::AXIS_W-1:0] ax,
        logic signed [tpma_pkg::AXIS_W-1:0] ay,
        logic signed [tpma_pkg::AXIS_W-1:0] az);
      longint unsigned sq;
      longint hx, vy, ang, dx, dy, q;
      sq  = longint'(ax) * longint'(ax) + longint'(az) * longint'(az);
      hx  = longint'(root64(sq << 32));
      vy  = longint'(ay) * 65536;
      ang = 0;
      for (int i = 0; i < 16; i++) begin
        dx = vy >>> i;
        dy = hx >>> i;
        if (vy > 0) begin
          hx  = hx + dx;
          vy  = vy - dy;
          ang = ang + ATAN_DEG16[i];
        end else if (vy < 0) begin
          hx  = hx - dx;
          vy  = vy + dy;
          ang = ang - ATAN_DEG16[i];
        end
      end
      // Round half away from zero, then clamp to +-90 degrees
      q = (ang >= 0) ? (ang + 128) / 256 : -((-ang + 128) / 256);
      if (q > tpma_pkg::PITCH_MAX) q = tpma_pkg::PITCH_MAX;
      if (q < -tpma_pkg::PITCH_MAX) q = -tpma_pkg::PITCH_MAX;
      return q[tpma_pkg::PITCH_W-1:0];
    endfunction

    // Accepted input beat: update the ring and queue the due result
    function void log_sample(logic signed [tpma_pkg::AXIS_W-1:0] ax,
                             logic signed [tpma_pkg::AXIS_W-1:0] ay,
                             logic signed [tpma_pkg::AXIS_W-1:0] az);
      pitch_result_t due;
      int            mean;
      due.pitch_now   = tilt_angle(ax, ay, az);
      ring_total      = ring_total - int'(ring[next_slot]) + int'(due.pitch_now);
      ring[next_slot] = due.pitch_now;
      next_slot       = (next_slot + 1 >= tpma_pkg::WINDOW) ? 0 : next_slot + 1;
      if (ring_total >= 0)
        mean = (ring_total + tpma_pkg::WINDOW / 2) / tpma_pkg::WINDOW;
      else
        mean = -((-ring_total + tpma_pkg::WINDOW / 2) / tpma_pkg::WINDOW);
      due.pitch_mean = mean[tpma_pkg::PITCH_W-1:0];
      pitch_due_q.push_back(due);
    endfunction

    // Accepted result beat: compare with the oldest due result
    function void match_result(logic [tpma_pkg::M_DATA_W-1:0] data);
      pitch_result_t due;
      logic signed [tpma_pkg::PITCH_W-1:0] got_now, got_mean;
      got_now  = data[15:0];
      got_mean = data[31:16];
      if (pitch_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected result beat: pitch_now %0d pitch_mean %0d",
                   got_now, got_mean);
      end else begin
        due = pitch_due_q.pop_front();
        if (got_now !== due.pitch_now || got_mean !== due.pitch_mean) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch: pitch_now exp %0d got %0d, pitch_mean exp %0d got %0d",
                     due.pitch_now, got_now, due.pitch_mean, got_mean);
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic [tpma_pkg::S_DATA_W-1:0]   s_tdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [tpma_pkg::M_DATA_W-1:0]   m_tdata;
  logic                            m_tvalid;
  logic                            m_tready;

  pitch_tracker tracker = new();
  bit           calm;
  bit           squeeze_req;

  tilt_pitch_moving_average_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one sample beat, hold it until taken, then maybe pause
  task automatic send_sample(input int ax, input int ay, input int az);
    logic signed [tpma_pkg::AXIS_W-1:0] sx, sy, sz;
    sx = ax[15:0];
    sy = ay[15:0];
    sz = az[15:0];
    s_tdata  <= {sz, sy, sx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    tracker.log_sample(sx, sy, sz);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Mix of full-range, small, vertical and steep samples
  task automatic send_random_sample();
    int kind;
    int ax, ay, az;
    kind = $urandom_range(0, 9);
    ax = $urandom;
    ay = $urandom;
    az = $urandom;
    if (kind >= 6 && kind < 8) begin
      // small counts: fine angles and rounding ties
      ax = $urandom_range(0, 32) - 16;
      ay = $urandom_range(0, 32) - 16;
      az = $urandom_range(0, 32) - 16;
    end else if (kind == 8) begin
      // no horizontal component
      ax = 0;
      az = 0;
    end else if (kind == 9) begin
      // near vertical, or level
      ax = $urandom_range(0, 64) - 32;
      az = $urandom_range(0, 64) - 32;
      if ($urandom_range(0, 3) == 0) ay = 0;
    end
    send_sample(ax, ay, az);
  endtask

  // Result side: random stalls plus one long hold-off
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) tracker.match_result(m_tdata);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = SQUEEZE_LEN;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any beat
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    calm        = 1'b0;
    squeeze_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero vector, vertical saturation, axis extremes
    send_sample(0, 0, 0);
    send_sample(0, 32767, 0);
    send_sample(0, -32768, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 0, 0);
    send_sample(0, 0, 32767);
    send_sample(1, 0, 0);
    send_sample(0, 1, 0);
    send_sample(0, -1, 0);
    send_sample(1, -1, 1);
    // Fill the window at the negative limit
    repeat (tpma_pkg::WINDOW) send_sample(0, -32768, 0);

    // Random part; the receiver holds off once early on
    squeeze_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random_sample();
    end
    s_tvalid <= 1'b0;

    // Drain, then watch for stray beats
    while (tracker.pitch_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_cnt == 0 && tracker.pitch_due_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
